>>> hdl/lzd_pkg.sv
// Shared types, constants and command codes of the LZ bitstream decompressor.
// Used by lzd_ctrl, lzd_datapath, lz_bitstream_decompressor and lzd_checker; depends on nothing.
package lzd_pkg;

    localparam int HistDepthDef = 4096;
    localparam int OutLanesDef  = 8;
    localparam logic [4:0] HdrLen  = 5'd18;
    localparam logic [4:0] SigLen  = 5'd4;
    localparam logic [31:0] CapReset = 32'hFFFF_FFFF;

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_HDR    = 5'd1;
    localparam logic [4:0] OP_DRAIN  = 5'd2;
    localparam logic [4:0] OP_TAKE   = 5'd3;
    localparam logic [4:0] OP_INIT   = 5'd4;
    localparam logic [4:0] OP_DBL    = 5'd5;
    localparam logic [4:0] OP_LITDBL = 5'd6;
    localparam logic [4:0] OP_LIT    = 5'd7;
    localparam logic [4:0] OP_CHK    = 5'd8;
    localparam logic [4:0] OP_REFILL = 5'd9;
    localparam logic [4:0] OP_RD     = 5'd10;
    localparam logic [4:0] OP_T2     = 5'd11;
    localparam logic [4:0] OP_LONG   = 5'd12;
    localparam logic [4:0] OP_G1     = 5'd13;
    localparam logic [4:0] OP_G3     = 5'd14;
    localparam logic [4:0] OP_D2     = 5'd15;
    localparam logic [4:0] OP_D4     = 5'd16;
    localparam logic [4:0] OP_D6     = 5'd17;
    localparam logic [4:0] OP_D7     = 5'd18;
    localparam logic [4:0] OP_COPY   = 5'd19;
    localparam logic [4:0] OP_RAWC   = 5'd20;
    localparam logic [4:0] OP_RAWB   = 5'd21;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [4:0] op;
        logic       accept;
        logic       em_rd;
        logic       em_wr;
        logic       out_clr;
        logic       done;
    } lzd_cmd_t;

    typedef struct packed {
        logic sig_bad;
        logic hdr_last;
        logic hdr_bad;
        logic drain_fin;
        logic exhausted;
        logic ctrl_need;
        logic ctrl_bit;
        logic dbl_carry;
        logic chk_zero;
        logic refill_carry;
        logic byte_zero;
        logic full;
        logic copy_bad;
        logic end_ok;
        logic g3_nine;
        logic raw_ge16;
        logic raw_one;
        logic dh_zero;
        logic len_zero;
        logic len_one;
        logic lanes_last;
    } lzd_sts_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h45;
            2'd1: b = 8'h52;
            2'd2: b = 8'h5A;
            default: b = 8'h02;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/lzd_datapath.sv
// Datapath of the LZ bitstream decompressor: header fields, control shift register,
// token registers, history memory and output lane packing. Depends on lzd_pkg.
module lzd_datapath #(
    parameter int HISTORY_DEPTH = lzd_pkg::HistDepthDef,
    parameter int OUT_LANES     = lzd_pkg::OutLanesDef
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic [7:0]       s_in_byte,
    input  lzd_pkg::lzd_cmd_t cmd,
    output lzd_pkg::lzd_sts_t sts,
    output logic [63:0]      m_out_bytes,
    output logic [3:0]       m_byte_count,
    output logic [31:0]      m_total_length
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = AW + 2;
    localparam logic [SW-1:0] DepthW = SW'(HISTORY_DEPTH);

    logic [31:0] cap_reg, dsize_reg, psize_reg, bin_reg, bout_reg;
    logic [4:0]  hpos_reg;
    logic [8:0]  shift_reg, ml_reg, len_reg;
    logic        carry_reg, copy_reg;
    logic [3:0]  dh_reg, cnt_reg;
    logic [6:0]  raw_reg;
    logic [7:0]  cur_reg, rdata_reg;
    logic [AW-1:0] hmod_reg, src_reg, wr_reg;
    logic [63:0] obuf_reg;
    logic [7:0]  hist_mem [HISTORY_DEPTH];

    logic        need, cbit;
    logic [8:0]  rd_shift, ml_m1, g3_val;
    logic [6:0]  raw_val, raw_conv;
    logic [4:0]  raw_sub;
    logic [12:0] distance;
    logic [31:0] room;
    logic [SW-1:0] src_raw, src_fix, hsum;
    logic [AW-1:0] hmod_lit, src_inc, wr_inc;
    logic [7:0]  em_data;

    always_comb begin
        need     = (shift_reg[6:0] == 7'd0);
        cbit     = need ? cur_reg[7] : shift_reg[7];
        rd_shift = need ? {cur_reg, shift_reg[7]} : {1'b0, shift_reg[6:0], 1'b0};
        ml_m1    = ml_reg - 9'd1;
        g3_val   = {ml_m1[7:0], cbit};
        raw_val  = {raw_reg[5:0], cbit};
        raw_sub  = 5'(raw_val - 7'd13);
        raw_conv = {raw_sub, 2'b00};
        distance = {1'b0, dh_reg, cur_reg} + 13'd1;
        room     = dsize_reg - bout_reg;
        src_raw  = SW'(hmod_reg) - SW'(distance);
        src_fix  = src_raw[SW-1] ? (src_raw + DepthW) : src_raw;
        hsum     = SW'(hmod_reg) + SW'(ml_reg);
        hmod_lit = (SW'(hmod_reg) + SW'(1) >= DepthW) ? '0 : AW'(hmod_reg + AW'(1));
        src_inc  = (SW'(src_reg) + SW'(1) >= DepthW) ? '0 : AW'(src_reg + AW'(1));
        wr_inc   = (SW'(wr_reg) + SW'(1) >= DepthW) ? '0 : AW'(wr_reg + AW'(1));
        em_data  = copy_reg ? rdata_reg : cur_reg;
    end

    always_comb begin
        sts.sig_bad      = (hpos_reg < SigLen) && (s_in_byte != sig_byte(hpos_reg[1:0]));
        sts.hdr_last     = (hpos_reg == HdrLen - 5'd1);
        sts.hdr_bad      = (psize_reg == 32'd0) || (dsize_reg > cap_reg);
        sts.drain_fin    = ({1'b0, bin_reg} + 33'd1) >= {1'b0, psize_reg};
        sts.exhausted    = (bin_reg >= psize_reg);
        sts.ctrl_need    = need;
        sts.ctrl_bit     = cbit;
        sts.dbl_carry    = shift_reg[7];
        sts.chk_zero     = (shift_reg[7:0] == 8'd0);
        sts.refill_carry = cur_reg[7];
        sts.byte_zero    = (cur_reg == 8'd0);
        sts.full         = (bout_reg >= dsize_reg);
        sts.copy_bad     = ({19'd0, distance} > bout_reg) || ({23'd0, ml_reg} > room);
        sts.end_ok       = (bout_reg == dsize_reg);
        sts.g3_nine      = (g3_val == 9'd9);
        sts.raw_ge16     = (raw_val >= 7'd16);
        sts.raw_one      = (raw_reg == 7'd1);
        sts.dh_zero      = (dh_reg == 4'd0);
        sts.len_zero     = (len_reg == 9'd0);
        sts.len_one      = (len_reg == 9'd1);
        sts.lanes_last   = (cnt_reg == 4'(OUT_LANES - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CapReset;
            dsize_reg <= '0;
            psize_reg <= '0;
            bin_reg   <= '0;
            bout_reg  <= '0;
            hpos_reg  <= '0;
            shift_reg <= '0;
            carry_reg <= 1'b0;
            ml_reg    <= '0;
            dh_reg    <= '0;
            raw_reg   <= '0;
            hmod_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            obuf_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                len_reg  <= '0;
                cnt_reg  <= '0;
                obuf_reg <= '0;
            end
            unique case (cmd.op)
                OP_HDR: begin
                    if (hpos_reg >= 5'd4 && hpos_reg < 5'd8) begin
                        dsize_reg <= {dsize_reg[23:0], s_in_byte};
                    end else if (hpos_reg >= 5'd8 && hpos_reg < 5'd12) begin
                        psize_reg <= {psize_reg[23:0], s_in_byte};
                    end
                    hpos_reg <= hpos_reg + 5'd1;
                end
                OP_DRAIN: bin_reg <= bin_reg + 32'd1;
                OP_TAKE: begin
                    bin_reg <= bin_reg + 32'd1;
                    cur_reg <= s_in_byte;
                end
                OP_INIT: begin
                    shift_reg <= {cur_reg[6:0], 2'b10};
                    carry_reg <= cur_reg[6];
                end
                OP_DBL: begin
                    shift_reg <= {shift_reg[7:0], 1'b0};
                    carry_reg <= shift_reg[7];
                end
                OP_LITDBL, OP_LIT, OP_RAWB: begin
                    copy_reg <= 1'b0;
                    wr_reg   <= hmod_reg;
                    hmod_reg <= hmod_lit;
                    len_reg  <= 9'd1;
                    bout_reg <= bout_reg + 32'd1;
                    if (cmd.op == OP_LITDBL) begin
                        shift_reg <= {shift_reg[7:0], 1'b0};
                        carry_reg <= shift_reg[7];
                    end
                    if (cmd.op == OP_RAWB) begin
                        raw_reg <= raw_reg - 7'd1;
                    end
                end
                OP_CHK: begin
                    shift_reg <= {1'b0, shift_reg[7:0]};
                    ml_reg    <= 9'd2;
                    dh_reg    <= 4'd0;
                end
                OP_REFILL: begin
                    shift_reg <= {cur_reg, carry_reg};
                    carry_reg <= cur_reg[7];
                    ml_reg    <= 9'd2;
                    dh_reg    <= 4'd0;
                end
                OP_RD, OP_T2, OP_G1, OP_G3, OP_D2, OP_D4, OP_D6, OP_D7, OP_RAWC: begin
                    shift_reg <= rd_shift;
                    carry_reg <= cbit;
                    unique case (cmd.op)
                        OP_T2: if (cbit) ml_reg <= 9'd3;
                        OP_G1: ml_reg <= {ml_reg[7:0], cbit};
                        OP_G3: begin
                            ml_reg <= g3_val;
                            if (g3_val == 9'd9) raw_reg <= 7'd1;
                        end
                        OP_D2: dh_reg <= {3'd0, cbit};
                        OP_D4: dh_reg <= {dh_reg[2:0], cbit} | 4'd4;
                        OP_D6: dh_reg <= {dh_reg[2:0], cbit};
                        OP_D7: dh_reg <= 4'd2 + {3'd0, cbit};
                        OP_RAWC: raw_reg <= (raw_val >= 7'd16) ? raw_conv : raw_val;
                        default: ;
                    endcase
                end
                OP_LONG: ml_reg <= {1'b0, cur_reg} + 9'd8;
                OP_COPY: begin
                    copy_reg <= 1'b1;
                    wr_reg   <= hmod_reg;
                    src_reg  <= AW'(src_fix);
                    hmod_reg <= AW'((hsum >= DepthW) ? (hsum - DepthW) : hsum);
                    len_reg  <= ml_reg;
                    bout_reg <= bout_reg + {23'd0, ml_reg};
                end
                default: ;
            endcase
            if (cmd.em_rd) begin
                src_reg <= src_inc;
            end
            if (cmd.em_wr) begin
                wr_reg  <= wr_inc;
                len_reg <= len_reg - 9'd1;
                cnt_reg <= cnt_reg + 4'd1;
                for (int i = 0; i < OUT_LANES; i++) begin
                    if (cnt_reg == 4'(i)) obuf_reg[8*i +: 8] <= em_data;
                end
            end
            if (cmd.out_clr) begin
                cnt_reg  <= '0;
                obuf_reg <= '0;
            end
        end
    end

    // History window: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.em_wr) begin
            hist_mem[wr_reg] <= em_data;
        end
        if (cmd.em_rd) begin
            rdata_reg <= hist_mem[src_reg];
        end
    end

    assign m_out_bytes    = obuf_reg;
    assign m_byte_count   = cnt_reg;
    assign m_total_length = cmd.done ? bout_reg : 32'd0;

endmodule

>>> hdl/lzd_ctrl.sv
// Controller of the LZ bitstream decompressor: the decode phase sequencer and the
// beat sequencer for input, history copy and output. Depends on lzd_pkg.
module lzd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last_byte,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_run_end,
    output logic [1:0]        m_status,
    input  lzd_pkg::lzd_sts_t sts,
    output lzd_pkg::lzd_cmd_t cmd
);
    import lzd_pkg::*;

    localparam logic [4:0] PH_HDR = 5'd0, PH_INIT = 5'd1, PH_DISP = 5'd2, PH_LIT1 = 5'd3,
        PH_LIT2 = 5'd4, PH_CHK = 5'd5, PH_REFILL = 5'd6, PH_T1 = 5'd7, PH_T2 = 5'd8,
        PH_T3 = 5'd9, PH_LONG = 5'd10, PH_G1 = 5'd11, PH_G2 = 5'd12, PH_G3 = 5'd13,
        PH_D1 = 5'd14, PH_D2 = 5'd15, PH_D3 = 5'd16, PH_D4 = 5'd17, PH_D5 = 5'd18,
        PH_D6 = 5'd19, PH_D7 = 5'd20, PH_MLO = 5'd21, PH_RAWC = 5'd22, PH_RAWB = 5'd23,
        PH_END = 5'd24, PH_DRAIN = 5'd25, PH_DONE = 5'd26, PH_ERR = 5'd27;

    localparam logic [2:0] SQ_IDLE = 3'd0, SQ_DEC = 3'd1, SQ_LAST = 3'd2, SQ_EMRD = 3'd3,
        SQ_EMWR = 3'd4, SQ_OUT = 3'd5;

    logic [4:0] phase_reg, phase_next;
    logic [2:0] seq_reg, seq_next;
    logic       have_reg, have_next, last_reg, last_next, run_end_reg, run_end_next;
    logic       byte_ph, rd_ph, hold;

    always_comb begin
        byte_ph = (phase_reg == PH_INIT) || (phase_reg == PH_LIT1) || (phase_reg == PH_LIT2)
               || (phase_reg == PH_REFILL) || (phase_reg == PH_LONG)
               || (phase_reg == PH_MLO) || (phase_reg == PH_RAWB);
        rd_ph   = (phase_reg == PH_T1) || (phase_reg == PH_T2) || (phase_reg == PH_T3)
               || (phase_reg == PH_G1) || (phase_reg == PH_G2) || (phase_reg == PH_G3)
               || (phase_reg == PH_D1) || (phase_reg == PH_D2) || (phase_reg == PH_D3)
               || (phase_reg == PH_D4) || (phase_reg == PH_D5) || (phase_reg == PH_D6)
               || (phase_reg == PH_D7) || (phase_reg == PH_RAWC) || (phase_reg == PH_END);
        hold    = !have_reg && (byte_ph || (rd_ph && sts.ctrl_need));
    end

    always_comb begin
        cmd          = '0;
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        have_next    = have_reg;
        last_next    = last_reg;
        run_end_next = run_end_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.done     = (phase_reg == PH_DONE);
        unique case (seq_reg)
            SQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    last_next  = s_last_byte;
                    seq_next   = SQ_LAST;
                    priority case (phase_reg)
                        PH_HDR: begin
                            cmd.op = OP_HDR;
                            if (sts.sig_bad) phase_next = PH_ERR;
                            else if (sts.hdr_last) phase_next = sts.hdr_bad ? PH_ERR : PH_INIT;
                        end
                        PH_DRAIN: begin
                            cmd.op = OP_DRAIN;
                            if (sts.drain_fin) phase_next = PH_DONE;
                        end
                        PH_DONE, PH_ERR: ;
                        default: begin
                            if (sts.exhausted) begin
                                phase_next = PH_ERR;
                            end else begin
                                cmd.op    = OP_TAKE;
                                have_next = 1'b1;
                                seq_next  = SQ_DEC;
                            end
                        end
                    endcase
                end
            end
            SQ_DEC: begin
                if (hold) begin
                    // A step needs a data byte that this beat no longer holds.
                    seq_next = SQ_LAST;
                    if (sts.exhausted) phase_next = PH_ERR;
                end else begin
                    if (byte_ph || (rd_ph && sts.ctrl_need)) have_next = 1'b0;
                    priority case (phase_reg)
                        PH_INIT: begin cmd.op = OP_INIT; phase_next = PH_DISP; end
                        PH_DISP: begin
                            cmd.op     = OP_DBL;
                            phase_next = sts.dbl_carry ? PH_CHK : PH_LIT1;
                        end
                        PH_LIT1: begin
                            if (sts.full) phase_next = PH_ERR;
                            else begin
                                cmd.op     = OP_LITDBL;
                                phase_next = sts.dbl_carry ? PH_CHK : PH_LIT2;
                            end
                        end
                        PH_LIT2: begin
                            if (sts.full) phase_next = PH_ERR;
                            else begin cmd.op = OP_LIT; phase_next = PH_DISP; end
                        end
                        PH_CHK: begin
                            cmd.op     = OP_CHK;
                            phase_next = sts.chk_zero ? PH_REFILL : PH_T1;
                        end
                        PH_REFILL: begin
                            cmd.op     = OP_REFILL;
                            phase_next = sts.refill_carry ? PH_T1 : PH_LIT2;
                        end
                        PH_T1: begin cmd.op = OP_RD; phase_next = sts.ctrl_bit ? PH_T2 : PH_G1; end
                        PH_T2: begin cmd.op = OP_T2; phase_next = sts.ctrl_bit ? PH_T3 : PH_MLO; end
                        PH_T3: begin cmd.op = OP_RD; phase_next = sts.ctrl_bit ? PH_LONG : PH_D1; end
                        PH_LONG: begin
                            cmd.op     = OP_LONG;
                            phase_next = sts.byte_zero ? PH_END : PH_D1;
                        end
                        PH_G1: begin cmd.op = OP_G1; phase_next = PH_G2; end
                        PH_G2: begin cmd.op = OP_RD; phase_next = sts.ctrl_bit ? PH_G3 : PH_D1; end
                        PH_G3: begin cmd.op = OP_G3; phase_next = sts.g3_nine ? PH_RAWC : PH_D1; end
                        PH_D1: begin cmd.op = OP_RD; phase_next = sts.ctrl_bit ? PH_D2 : PH_MLO; end
                        PH_D2: begin cmd.op = OP_D2; phase_next = PH_D3; end
                        PH_D3: begin
                            cmd.op = OP_RD;
                            if (sts.ctrl_bit) phase_next = PH_D4;
                            else phase_next = sts.dh_zero ? PH_D7 : PH_MLO;
                        end
                        PH_D4: begin cmd.op = OP_D4; phase_next = PH_D5; end
                        PH_D5: begin cmd.op = OP_RD; phase_next = sts.ctrl_bit ? PH_MLO : PH_D6; end
                        PH_D6: begin cmd.op = OP_D6; phase_next = PH_MLO; end
                        PH_D7: begin cmd.op = OP_D7; phase_next = PH_MLO; end
                        PH_MLO: begin
                            if (sts.copy_bad) phase_next = PH_ERR;
                            else begin cmd.op = OP_COPY; phase_next = PH_DISP; end
                        end
                        PH_RAWC: begin
                            cmd.op = OP_RAWC;
                            if (sts.raw_ge16) phase_next = PH_RAWB;
                        end
                        PH_RAWB: begin
                            if (sts.full) phase_next = PH_ERR;
                            else begin
                                cmd.op     = OP_RAWB;
                                phase_next = sts.raw_one ? PH_DISP : PH_RAWB;
                            end
                        end
                        PH_END: begin
                            cmd.op   = OP_RD;
                            seq_next = SQ_LAST;
                            if (sts.ctrl_bit) begin
                                phase_next = PH_DISP;
                                seq_next   = SQ_DEC;
                            end else if (!sts.end_ok) phase_next = PH_ERR;
                            else phase_next = sts.exhausted ? PH_DONE : PH_DRAIN;
                        end
                        default: seq_next = SQ_LAST;
                    endcase
                    if (phase_next == PH_ERR) seq_next = SQ_LAST;
                end
            end
            SQ_LAST: begin
                if (last_reg && phase_reg != PH_DONE && phase_reg != PH_ERR) phase_next = PH_ERR;
                if (sts.len_zero) begin
                    seq_next     = SQ_OUT;
                    run_end_next = 1'b1;
                end else begin
                    seq_next = SQ_EMRD;
                end
            end
            SQ_EMRD: begin
                cmd.em_rd = 1'b1;
                seq_next  = SQ_EMWR;
            end
            SQ_EMWR: begin
                cmd.em_wr = 1'b1;
                if (sts.len_one || sts.lanes_last) begin
                    seq_next     = SQ_OUT;
                    run_end_next = sts.len_one;
                end else begin
                    seq_next = SQ_EMRD;
                end
            end
            SQ_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.out_clr = 1'b1;
                    seq_next    = run_end_reg ? SQ_IDLE : SQ_EMRD;
                end
            end
            default: seq_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            seq_reg     <= SQ_IDLE;
            have_reg    <= 1'b0;
            last_reg    <= 1'b0;
            run_end_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            have_reg    <= have_next;
            last_reg    <= last_next;
            run_end_reg <= run_end_next;
        end
    end

    assign m_run_end = run_end_reg;
    assign m_status  = (phase_reg == PH_ERR) ? ST_ERR : ((phase_reg == PH_DONE) ? ST_DONE : ST_RUN);

endmodule

>>> hdl/lz_bitstream_decompressor.sv
// Top level of the LZ bitstream decompressor: controller plus datapath.
// Depends on lzd_pkg, lzd_ctrl and lzd_datapath.
//
// The block takes a container one byte per beat, checks its header and decodes
// the packed stream, giving one or more result beats per input beat. A header
// or drained byte goes from acceptance through the last-byte check to its output
// beat before the next ready. A data byte runs one decode step at a time, then each
// decoded byte takes a read and then a write through the history memory, whose
// single registered read port sets the copy rate; each group of up to eight bytes
// is one result beat, held until taken.
module lz_bitstream_decompressor #(
    parameter int HISTORY_DEPTH = lzd_pkg::HistDepthDef,
    parameter int OUT_LANES     = lzd_pkg::OutLanesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_bytes,
    output logic [3:0]  m_byte_count,
    output logic        m_run_end,
    output logic [1:0]  m_status,
    output logic [31:0] m_total_length
);
    import lzd_pkg::*;

    lzd_cmd_t cmd;
    lzd_sts_t sts;

    lzd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_run_end   (m_run_end),
        .m_status    (m_status),
        .sts         (sts),
        .cmd         (cmd)
    );

    lzd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_LANES     (OUT_LANES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_in_byte      (s_in_byte),
        .cmd            (cmd),
        .sts            (sts),
        .m_out_bytes    (m_out_bytes),
        .m_byte_count   (m_byte_count),
        .m_total_length (m_total_length)
    );

endmodule

>>> tb/lzd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the LZ bitstream decompressor: follows both channels and the capacity port,
// predicts every result beat from the accepted input beats and compares them. Depends on lzd_pkg.
module lzd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_out_bytes,
    input  logic [3:0]  m_byte_count,
    input  logic        m_run_end,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_total_length,
    output int          mismatches,
    output int          outstanding,
    output int          beats_checked
);
    import lzd_pkg::*;

    localparam int Lanes = OutLanesDef;
    localparam int Depth = HistDepthDef;
    localparam logic [31:0] Signature = 32'h4552_5A02;

    typedef enum logic [4:0] {
        PH_HDR, PH_INIT, PH_DISP, PH_LIT1, PH_LIT2, PH_CHK, PH_REFILL,
        PH_T1, PH_T2, PH_T3, PH_LONG, PH_G1, PH_G2, PH_G3,
        PH_D1, PH_D2, PH_D3, PH_D4, PH_D5, PH_D6, PH_D7,
        PH_MLO, PH_RAWC, PH_RAWB, PH_END, PH_DRAIN, PH_DONE, PH_ERR
    } dec_phase_e;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        run_end;
        logic [1:0]  status;
        logic [31:0] total;
    } out_beat_t;

    logic [31:0] capacity;
    logic [8:0]  cshift;
    logic        ccarry;
    dec_phase_e  dphase;
    logic [4:0]  hdr_pos;
    logic [31:0] decoded_len, packed_len, data_in, out_cnt;
    logic [8:0]  mlen;
    logic [3:0]  dhigh;
    logic [6:0]  raw_left;
    logic [7:0]  hist [Depth];
    logic        have_in;
    logic [7:0]  cur_in;
    logic [63:0] lane_acc;
    int          lane_n;
    out_beat_t   groups_q[$];
    out_beat_t   expected_q[$];
    int          errs;
    int          checked;

    function automatic void reset_model();
        capacity = CapReset;
        cshift = '0; ccarry = 1'b0; dphase = PH_HDR; hdr_pos = '0;
        decoded_len = '0; packed_len = '0; data_in = '0; out_cnt = '0;
        mlen = '0; dhigh = '0; raw_left = '0; have_in = 1'b0; cur_in = '0;
    endfunction

    // Running out of packed data while a byte is needed is an error at once.
    function automatic bit byte_avail();
        if (have_in) return 1'b1;
        if (data_in >= packed_len) dphase = PH_ERR;
        return 1'b0;
    endfunction

    function automatic logic [7:0] take_in();
        have_in = 1'b0;
        return cur_in;
    endfunction

    // One control bit, refilling the shift register from the stream when only the
    // sentinel is left. Returns -1 when the decoder has to wait for a byte.
    function automatic int ctrl_bit();
        logic [8:0] d;
        if (cshift[6:0] == 7'd0 && !byte_avail()) return -1;
        d = {cshift[7:0], 1'b0};
        ccarry = d[8];
        if (d[7:0] == 8'd0) begin
            d = {take_in(), ccarry};
            ccarry = d[8];
            cshift = d;
        end else begin
            cshift = {1'b0, d[7:0]};
        end
        return int'(ccarry);
    endfunction

    function automatic bit emit(input logic [7:0] b);
        if (out_cnt >= decoded_len) begin
            dphase = PH_ERR;
            return 1'b0;
        end
        hist[out_cnt % Depth] = b;
        out_cnt++;
        lane_acc[8*lane_n +: 8] = b;
        lane_n++;
        if (lane_n >= Lanes) begin
            groups_q.push_back('{bytes: lane_acc, count: 4'(lane_n), default: '0});
            lane_acc = '0;
            lane_n = 0;
        end
        return 1'b1;
    endfunction

    function automatic void double_ctrl();
        cshift = {cshift[7:0], 1'b0};
        ccarry = cshift[8];
    endfunction

    function automatic void start_token();
        mlen = 9'd2;
        dhigh = '0;
        dphase = PH_T1;
    endfunction

    function automatic void run_decoder();
        int b;
        int i;
        logic [7:0] v;
        logic [31:0] back;
        while (1'b1) begin
            case (dphase)
                PH_INIT: begin
                    if (!byte_avail()) return;
                    v = take_in();
                    cshift = {v[6:0], 2'b10};
                    ccarry = cshift[8];
                    dphase = PH_DISP;
                end
                PH_DISP: begin
                    double_ctrl();
                    dphase = ccarry ? PH_CHK : PH_LIT1;
                end
                PH_LIT1: begin
                    if (!byte_avail()) return;
                    if (!emit(take_in())) return;
                    double_ctrl();
                    dphase = ccarry ? PH_CHK : PH_LIT2;
                end
                PH_LIT2: begin
                    if (!byte_avail()) return;
                    if (!emit(take_in())) return;
                    dphase = PH_DISP;
                end
                PH_CHK: begin
                    cshift[8] = 1'b0;
                    if (cshift == 9'd0) dphase = PH_REFILL;
                    else start_token();
                end
                PH_REFILL: begin
                    if (!byte_avail()) return;
                    cshift = {take_in(), ccarry};
                    ccarry = cshift[8];
                    if (!ccarry) dphase = PH_LIT2;
                    else start_token();
                end
                PH_T1: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dphase = b ? PH_T2 : PH_G1;
                end
                PH_T2: begin
                    if ((b = ctrl_bit()) < 0) return;
                    if (b == 0) begin
                        dphase = PH_MLO;
                    end else begin
                        mlen = 9'd3;
                        dphase = PH_T3;
                    end
                end
                PH_T3: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dphase = b ? PH_LONG : PH_D1;
                end
                PH_LONG: begin
                    if (!byte_avail()) return;
                    v = take_in();
                    if (v == 8'd0) begin
                        dphase = PH_END;
                    end else begin
                        mlen = 9'(v) + 9'd8;
                        dphase = PH_D1;
                    end
                end
                PH_G1: begin
                    if ((b = ctrl_bit()) < 0) return;
                    mlen = mlen * 2 + 9'(b);
                    dphase = PH_G2;
                end
                PH_G2: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dphase = b ? PH_G3 : PH_D1;
                end
                PH_G3: begin
                    if ((b = ctrl_bit()) < 0) return;
                    mlen = (mlen - 9'd1) * 2 + 9'(b);
                    if (mlen == 9'd9) begin
                        raw_left = 7'd1;
                        dphase = PH_RAWC;
                    end else begin
                        dphase = PH_D1;
                    end
                end
                PH_D1: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dphase = b ? PH_D2 : PH_MLO;
                end
                PH_D2: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dhigh = 4'(b);
                    dphase = PH_D3;
                end
                PH_D3: begin
                    if ((b = ctrl_bit()) < 0) return;
                    if (b != 0) dphase = PH_D4;
                    else dphase = (dhigh == 4'd0) ? PH_D7 : PH_MLO;
                end
                PH_D4: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dhigh = (dhigh * 2 + 4'(b)) | 4'd4;
                    dphase = PH_D5;
                end
                PH_D5: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dphase = b ? PH_MLO : PH_D6;
                end
                PH_D6: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dhigh = dhigh * 2 + 4'(b);
                    dphase = PH_MLO;
                end
                PH_D7: begin
                    if ((b = ctrl_bit()) < 0) return;
                    dhigh = 4'd2 + 4'(b);
                    dphase = PH_MLO;
                end
                PH_MLO: begin
                    if (!byte_avail()) return;
                    v = take_in();
                    back = (32'(dhigh) << 8) + 32'(v) + 32'd1;
                    if (back > out_cnt || 32'(mlen) > decoded_len - out_cnt) begin
                        dphase = PH_ERR;
                        return;
                    end
                    for (i = 0; i < int'(mlen); i++)
                        if (!emit(hist[(out_cnt - back) % Depth])) return;
                    dphase = PH_DISP;
                end
                PH_RAWC: begin
                    if ((b = ctrl_bit()) < 0) return;
                    raw_left = raw_left * 2 + 7'(b);
                    if (raw_left >= 7'd16) begin
                        raw_left = (raw_left - 7'd16 + 7'd3) * 4;
                        dphase = PH_RAWB;
                    end
                end
                PH_RAWB: begin
                    if (!byte_avail()) return;
                    if (!emit(take_in())) return;
                    raw_left--;
                    if (raw_left == 7'd0) dphase = PH_DISP;
                end
                PH_END: begin
                    if ((b = ctrl_bit()) < 0) return;
                    if (b != 0) begin
                        dphase = PH_DISP;
                    end else begin
                        if (out_cnt != decoded_len) dphase = PH_ERR;
                        else dphase = (data_in >= packed_len) ? PH_DONE : PH_DRAIN;
                        return;
                    end
                end
                default: return;
            endcase
        end
    endfunction

    // Works out every result beat that one container byte causes.
    function automatic void predict_beats(input logic [7:0] b, input logic last);
        int p;
        int k;
        logic [1:0] st;
        logic [31:0] tot;
        out_beat_t beat;
        groups_q.delete();
        lane_n = 0;
        lane_acc = '0;
        if (dphase == PH_HDR) begin
            p = int'(hdr_pos);
            if (p < 4) begin
                if (b != Signature[31-8*p -: 8]) dphase = PH_ERR;
            end else if (p < 8) begin
                decoded_len = {decoded_len[23:0], b};
            end else if (p < 12) begin
                packed_len = {packed_len[23:0], b};
            end
            if (dphase == PH_HDR) begin
                hdr_pos = 5'(p + 1);
                if (hdr_pos >= HdrLen) begin
                    if (packed_len == 32'd0 || decoded_len > capacity) dphase = PH_ERR;
                    else dphase = PH_INIT;
                end
            end
        end else if (dphase == PH_DRAIN) begin
            data_in++;
            if (data_in >= packed_len) dphase = PH_DONE;
        end else if (dphase != PH_DONE && dphase != PH_ERR) begin
            if (data_in < packed_len) begin
                data_in++;
                have_in = 1'b1;
                cur_in = b;
                run_decoder();
                have_in = 1'b0;
            end else begin
                dphase = PH_ERR;
            end
        end

        if (last && dphase != PH_DONE && dphase != PH_ERR) dphase = PH_ERR;

        if (lane_n > 0) groups_q.push_back('{bytes: lane_acc, count: 4'(lane_n), default: '0});
        if (groups_q.size() == 0) groups_q.push_back('0);
        st = (dphase == PH_ERR) ? ST_ERR : ((dphase == PH_DONE) ? ST_DONE : ST_RUN);
        tot = (dphase == PH_DONE) ? out_cnt : 32'd0;
        for (k = 0; k < groups_q.size(); k++) begin
            beat = groups_q[k];
            beat.run_end = (k == groups_q.size() - 1);
            beat.status = st;
            beat.total = tot;
            expected_q.push_back(beat);
        end
    endfunction

    function automatic void report_field(input string name, input logic [63:0] exp_v,
                                         input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        out_beat_t exp_b;
        if (!aresetn) begin
            reset_model();
            expected_q.delete();
            errs = 0;
            checked = 0;
        end else begin
            if (cfg_wr_en) capacity = cfg_wr_data;
            if (s_valid && s_ready) predict_beats(s_in_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing, got %h/%0d",
                             $time, m_out_bytes, m_byte_count);
                    errs++;
                end else begin
                    exp_b = expected_q.pop_front();
                    checked++;
                    report_field("out_bytes", exp_b.bytes, m_out_bytes);
                    report_field("byte_count", 64'(exp_b.count), 64'(m_byte_count));
                    report_field("run_end", 64'(exp_b.run_end), 64'(m_run_end));
                    report_field("status", 64'(exp_b.status), 64'(m_status));
                    report_field("total_length", 64'(exp_b.total), 64'(m_total_length));
                end
            end
        end
        mismatches <= errs;
        outstanding <= expected_q.size();
        beats_checked <= checked;
    end

endmodule

>>> tb/lz_bitstream_decompressor_test.sv
`timescale 1ns / 1ps
// Top of the decompressor testbench: builds one well-formed container with its own encoder,
// streams it into the block under random idling and gives the verdict. Depends on the block and lzd_checker.
module lz_bitstream_decompressor_test;

    localparam int CycleLimit = 500000;
    localparam int RandomBytes = 30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_bytes;
    logic [3:0]  m_byte_count;
    logic        m_run_end;
    logic [1:0]  m_status;
    logic [31:0] m_total_length;

    int mismatches;
    int outstanding;
    int beats_checked;
    int cycles = 0;
    int sent = 0;
    bit calm = 1'b0;

    // Packed stream under construction; control bytes are reserved in the stream at the
    // point where the decoder will run out of control bits.
    logic [7:0] stream_q[$];
    int ctl_pos;
    int ctl_left;
    int produced;

    lz_bitstream_decompressor dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_byte(s_in_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_bytes(m_out_bytes),
        .m_byte_count(m_byte_count), .m_run_end(m_run_end), .m_status(m_status),
        .m_total_length(m_total_length)
    );

    lzd_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_byte(s_in_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_bytes(m_out_bytes),
        .m_byte_count(m_byte_count), .m_run_end(m_run_end), .m_status(m_status),
        .m_total_length(m_total_length),
        .mismatches(mismatches), .outstanding(outstanding), .beats_checked(beats_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side stalls in short bursts until the closing stretch.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic void put_bit(input bit b);
        logic [7:0] tmp;
        if (ctl_left == 0) begin
            ctl_pos = stream_q.size();
            stream_q.push_back(8'($urandom));
            ctl_left = 8;
        end
        ctl_left--;
        tmp = stream_q[ctl_pos];
        tmp[ctl_left] = b;
        stream_q[ctl_pos] = tmp;
    endfunction

    function automatic void put_bits(input int value, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) put_bit(bit'((value >> i) & 1));
    endfunction

    function automatic void enc_literal(input logic [7:0] b);
        put_bit(1'b0);
        stream_q.push_back(b);
        produced++;
    endfunction

    function automatic void enc_distance(input int back);
        int d;
        int dh;
        d = back - 1;
        dh = d >> 8;
        if (dh == 0) put_bits(0, 1);
        else if (dh == 1) put_bits(3'b110, 3);
        else if (dh < 4) put_bits(4'b1000 | (dh - 2), 4);
        else if (dh < 8) put_bits(5'b10101 | (((dh - 4) & 2) << 2) | (((dh - 4) & 1) << 1), 5);
        else put_bits(6'b101000 | (((dh - 8) & 4) << 2) | (((dh - 8) & 2) << 1)
                      | ((dh - 8) & 1), 6);
        stream_q.push_back(8'(d));
    endfunction

    // Lengths 2 to 8 use the short codes, longer ones an extra length byte.
    function automatic void enc_match(input int len, input int back);
        put_bit(1'b1);
        if (len == 2) begin
            put_bits(2'b10, 2);
            stream_q.push_back(8'(back - 1));
        end else begin
            if (len == 3) put_bits(3'b110, 3);
            else if (len < 6) put_bits((len - 4) << 1, 3);
            else if (len < 8) put_bits(2 + (len - 6), 4);
            else if (len == 8) put_bits(4'b0110, 4);
            else begin
                put_bits(3'b111, 3);
                stream_q.push_back(8'(len - 8));
            end
            enc_distance(back);
        end
        produced += len;
    endfunction

    function automatic void enc_raw(input int k);
        int i;
        put_bit(1'b1);
        put_bits(4'b0111, 4);
        put_bits(k, 4);
        for (i = 0; i < (k + 3) * 4; i++) stream_q.push_back(8'($urandom));
        produced += (k + 3) * 4;
    endfunction

    // The end escape; with carry_on set it is a no-op and decoding goes on.
    function automatic void enc_escape(input bit carry_on);
        put_bit(1'b1);
        put_bits(3'b111, 3);
        stream_q.push_back(8'd0);
        put_bit(carry_on);
    endfunction

    function automatic int pick_distance(input int cap);
        int maxd;
        maxd = (produced < 4096) ? produced : 4096;
        if (maxd > cap) maxd = cap;
        case ($urandom_range(0, 3))
            0: return 1;
            1: return $urandom_range(1, (maxd < 16) ? maxd : 16);
            2: return $urandom_range(1, maxd);
            default: return maxd;
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [7:0] header [18];
        int i;
        int len;
        int sel;
        int directed_len;
        int pause_at;
        logic [31:0] packed_len;

        stream_q.push_back(8'($urandom));
        ctl_pos = 0;
        ctl_left = 6;
        produced = 0;

        // Directed opening: byte extremes, every length code, a short raw run, the no-op
        // escape, then long repeats that fill the history so far distances become legal.
        enc_literal(8'h00);
        enc_literal(8'hFF);
        enc_match(2, 1);
        enc_match(3, 2);
        for (len = 4; len <= 8; len++) enc_match(len, pick_distance(4096));
        enc_raw(0);
        enc_escape(1'b1);
        for (i = 0; i < 16; i++) enc_match(263, (i == 0) ? 1 : pick_distance(4096));
        enc_match(9, 4096);
        enc_match(2, 256);
        directed_len = stream_q.size();

        while (stream_q.size() < directed_len + RandomBytes) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) enc_literal(8'($urandom));
            else if (sel < 80) begin
                len = $urandom_range(2, 8);
                enc_match(len, pick_distance((len == 2) ? 256 : 4096));
            end else if (sel < 88) begin
                len = ($urandom_range(0, 5) == 0) ? 263 : $urandom_range(9, 30);
                enc_match(len, pick_distance(4096));
            end else if (sel < 94) enc_raw(($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 2));
            else enc_escape(1'b1);
        end
        enc_escape(1'b0);

        // Two drain bytes follow the stream, so the finish waits for the packed size.
        packed_len = 32'(stream_q.size() + 2);
        header = '{8'h45, 8'h52, 8'h5A, 8'h02,
                   produced[31:24], produced[23:16], produced[15:8], produced[7:0],
                   packed_len[31:24], packed_len[23:16], packed_len[15:8], packed_len[7:0],
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom)};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_capacity(32'd0);
        for (i = 0; i < 6; i++) send_beat(header[i], 1'b0);
        write_capacity(32'hFFFF_FFFF);
        for (i = 6; i < 12; i++) send_beat(header[i], 1'b0);
        // The decoded size sits exactly on the capacity when the header closes.
        write_capacity(32'(produced));
        for (i = 12; i < 18; i++) send_beat(header[i], 1'b0);

        pause_at = $urandom_range(directed_len, stream_q.size() - 1);
        for (i = 0; i < stream_q.size(); i++) begin
            if (i == pause_at) drain_results();
            if (i == stream_q.size() - 20) calm = 1'b1;
            send_beat(stream_q[i], 1'b0);
        end
        for (i = 0; i < 2; i++) send_beat(8'($urandom), 1'b0);
        // Bytes past the packed data are ignored; the final one carries the last flag.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'($urandom), 1'b1);

        write_capacity(32'd0);
        write_capacity($urandom);
        drain_results();
        repeat (600) @(posedge aclk);

        $display("Sent %0d container beats (%0d decoded bytes) and checked %0d result beats,",
                 sent, produced, beats_checked);
        $display("covering literals, all match length codes, far distances, raw runs and escapes.");
        if (mismatches == 0 && outstanding == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
